[rtl/tasp_pkg.sv]
// Shared types, constants and the control store of the arc slider position core.
package tasp_pkg;

	// Coordinate width of touch points and of the arc centre.
	localparam int CoordBits = 12;
	localparam int DeltaW    = CoordBits + 1;
	localparam int AngW      = 9;
	localparam int LevelW    = 7;

	// Configuration port.
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = (CoordBits > AngW) ? CoordBits : AngW;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_CENTRE_X  = 3'd0,
		CFG_CENTRE_Y  = 3'd1,
		CFG_ARC_START = 3'd2,
		CFG_ARC_SWEEP = 3'd3,
		CFG_ENABLED   = 3'd4
	} cfg_idx_t;

	// Touch actions.
	localparam logic [1:0] ActDown   = 2'd0;
	localparam logic [1:0] ActMove   = 2'd1;
	localparam logic [1:0] ActUp     = 2'd2;
	localparam logic [1:0] ActCancel = 2'd3;

	// Angle and level constants.
	localparam int AtanScale = 45;
	localparam int PctScale  = 100;
	localparam logic [AngW-1:0]   Deg90   = AngW'(90);
	localparam logic [AngW-1:0]   Deg180  = AngW'(180);
	localparam logic [AngW-1:0]   Deg360  = AngW'(360);
	localparam logic [LevelW-1:0] Pct100  = LevelW'(PctScale);
	localparam logic [AngW-1:0]   StartRst = AngW'(150);
	localparam logic [AngW-1:0]   SweepRst = AngW'(240);

	// Shared shift-subtract divider. The octant ratio needs six quotient bits
	// (at most 45), the level seven (at most 100).
	localparam int AtanQBits  = 6;
	localparam int ScaleQBits = 7;
	localparam int QuoW       = ScaleQBits;
	localparam int CntW       = 3;
	localparam int RemW       = (CoordBits + AtanQBits > 16) ? CoordBits + AtanQBits : 16;

	// Sequencer.
	localparam int StepW = 4;
	typedef logic [StepW-1:0] step_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LATCH,
		OP_DELTA,
		OP_ATAN_SETUP,
		OP_DIV,
		OP_ANGLE,
		OP_REL,
		OP_SCALE_SETUP,
		OP_COMMIT,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_BEAT,
		COND_NO_TRACK,
		COND_DIV_MORE,
		COND_OUTSIDE,
		COND_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} uword_t;

	localparam step_t StepLatch      = 4'd0;
	localparam step_t StepDelta      = 4'd1;
	localparam step_t StepAtanSetup  = 4'd2;
	localparam step_t StepAtanDiv    = 4'd3;
	localparam step_t StepAngle      = 4'd4;
	localparam step_t StepRel        = 4'd5;
	localparam step_t StepScaleSetup = 4'd6;
	localparam step_t StepScaleDiv   = 4'd7;
	localparam step_t StepCommit     = 4'd8;
	localparam step_t StepEmit       = 4'd9;
	localparam step_t StepLast       = StepEmit;

	// Control store. A word jumps to its target when its condition holds,
	// otherwise it falls through to the next step; the last step wraps.
	function automatic uword_t ucode(input step_t s);
		uword_t w;
		case (s)
			StepLatch:      w = '{OP_LATCH,       COND_NO_BEAT,  StepLatch};
			StepDelta:      w = '{OP_DELTA,       COND_NO_TRACK, StepEmit};
			StepAtanSetup:  w = '{OP_ATAN_SETUP,  COND_NEVER,    StepLatch};
			StepAtanDiv:    w = '{OP_DIV,         COND_DIV_MORE, StepAtanDiv};
			StepAngle:      w = '{OP_ANGLE,       COND_NEVER,    StepLatch};
			StepRel:        w = '{OP_REL,         COND_NEVER,    StepLatch};
			StepScaleSetup: w = '{OP_SCALE_SETUP, COND_OUTSIDE,  StepCommit};
			StepScaleDiv:   w = '{OP_DIV,         COND_DIV_MORE, StepScaleDiv};
			StepCommit:     w = '{OP_COMMIT,      COND_NEVER,    StepLatch};
			StepEmit:       w = '{OP_EMIT,        COND_OUT_BUSY, StepEmit};
			default:        w = '{OP_NOP,         COND_ALWAYS,   StepLatch};
		endcase
		return w;
	endfunction

endpackage

[rtl/touch_arc_slider_position_core.sv]
// Arc slider touch tracker: microcoded sequencer with a shared shift-subtract divider.
// Each beat is latched; up, cancel, disabled and untracked moves then go straight to the
// emit step, while tracked down and move beats run the atan division (six divider steps),
// angle, relative angle, level division (seven steps, skipped when the point snaps) and
// commit. A new beat waits until the last is emitted; a waiting result holds the emit step.
// Reset (arst_n low, asynchronous): not dragging, level 0, configuration registers at their defaults.
module touch_arc_slider_position_core
	import tasp_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// Touch event channel.
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           action,
	input  logic [CoordBits-1:0] touch_x,
	input  logic [CoordBits-1:0] touch_y,
	// Result channel.
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 handled,
	output logic [LevelW-1:0]    level,
	output logic                 level_changed,
	output logic [AngW-1:0]      angle_deg,
	// Configuration write port.
	input  logic                 cfg_we,
	input  logic [CfgIdxW-1:0]   cfg_index,
	input  logic [CfgDataW-1:0]  cfg_data
);

	// Configuration registers.
	logic [CoordBits-1:0] cx_q, cy_q;
	logic [AngW-1:0]      start_q, sweep_q;
	logic                 enabled_q;

	// Architectural state.
	logic                 dragging_q;
	logic [LevelW-1:0]    slider_level_q;

	// Sequencer.
	step_t                step_q, step_next;
	uword_t               uw;
	logic                 take_jump;

	// Latched event and working registers.
	logic [CoordBits-1:0] tx_q, ty_q;
	logic                 handled_q, track_q;
	logic [DeltaW-1:0]    dx_q, dy_q;
	logic                 xneg_q, yneg_q, steep_q, zero_q;
	logic [RemW-1:0]      rem_q, dsh_q;
	logic [QuoW-1:0]      quo_q;
	logic [CntW-1:0]      cnt_q;
	logic [AngW-1:0]      ang_q, rel_q, sw_q;
	logic                 inside_q, changed_q;
	logic [LevelW-1:0]    snap_q;

	// Output register.
	logic                 out_valid_q;
	logic                 out_handled_q, out_changed_q;
	logic [LevelW-1:0]    out_level_q;
	logic [AngW-1:0]      out_angle_q;

	// Combinational datapath.
	logic                 beat_in, out_busy;
	logic [DeltaW-1:0]    dx_neg, dy_neg;
	logic [CoordBits-1:0] ax, ay, mn, mx;
	logic                 steep;
	logic                 div_ge;
	logic [AngW-1:0]      q_ang, a0, a1, a2, ang_new;
	logic [AngW-1:0]      start_m, rel_new, sw_new;
	logic                 in_arc;
	logic [LevelW-1:0]    snap_new, lvl_new;

	// The control word for the current step drives everything below.
	assign uw       = ucode(step_q);
	assign in_ready = (uw.op == OP_LATCH);
	assign beat_in  = in_valid && in_ready;
	assign out_busy = out_valid_q && !out_ready;

	// Octant folding: magnitudes, and min over max for the ratio 45*min/max.
	always_comb begin
		dx_neg = '0 - dx_q;
		dy_neg = '0 - dy_q;
		ax     = dx_q[DeltaW-1] ? dx_neg[CoordBits-1:0] : dx_q[CoordBits-1:0];
		ay     = dy_q[DeltaW-1] ? dy_neg[CoordBits-1:0] : dy_q[CoordBits-1:0];
		steep  = (ax < ay);
		mn     = steep ? ax : ay;
		mx     = steep ? ay : ax;
	end

	// One restoring step of the divider: the divisor is pre-shifted to the top
	// quotient bit and moves right by one each step.
	assign div_ge = (rem_q >= dsh_q);

	// Unfold the octant ratio into a full-circle angle. Screen y points down,
	// so angles run clockwise. A point on the centre has angle 0, and an angle
	// that unfolds to 360 wraps to 0.
	always_comb begin
		q_ang   = AngW'(quo_q);
		a0      = steep_q ? (Deg90 - q_ang) : q_ang;
		a1      = xneg_q ? (Deg180 - a0) : a0;
		a2      = yneg_q ? (Deg360 - a1) : a1;
		ang_new = (zero_q || (a2 == Deg360)) ? '0 : a2;
	end

	// Angle relative to the arc start. A start beyond a full turn is folded
	// back once, which covers the whole 9-bit range. Modulo-512 arithmetic
	// gives the right wrapped value because the true result is below 360.
	always_comb begin
		start_m = (start_q >= Deg360) ? (start_q - Deg360) : start_q;
		rel_new = (ang_q >= start_m) ? (ang_q - start_m) : (ang_q + Deg360 - start_m);
		sw_new  = (sweep_q == '0) ? AngW'(1) : sweep_q;
	end

	// Outside the sweep the level snaps to the nearer end; a tie goes to 100.
	always_comb begin
		in_arc   = (rel_q <= sw_q);
		snap_new = ((Deg360 - rel_q) < (rel_q - sw_q)) ? '0 : Pct100;
		lvl_new  = inside_q ? quo_q[LevelW-1:0] : snap_q;
	end

	// Jump conditions and next step.
	always_comb begin
		case (uw.cond)
			COND_NEVER:    take_jump = 1'b0;
			COND_ALWAYS:   take_jump = 1'b1;
			COND_NO_BEAT:  take_jump = !beat_in;
			COND_NO_TRACK: take_jump = !track_q;
			COND_DIV_MORE: take_jump = (cnt_q != '0);
			COND_OUTSIDE:  take_jump = !in_arc;
			COND_OUT_BUSY: take_jump = out_busy;
			default:       take_jump = 1'b0;
		endcase
		if (take_jump) begin
			step_next = uw.target;
		end else if (step_q == StepLast) begin
			step_next = StepLatch;
		end else begin
			step_next = step_q + step_t'(1);
		end
	end

	// Control state: configuration, drag flag, level, step counter, result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q           <= '0;
			cy_q           <= '0;
			start_q        <= StartRst;
			sweep_q        <= SweepRst;
			enabled_q      <= 1'b1;
			dragging_q     <= 1'b0;
			slider_level_q <= '0;
			step_q         <= StepLatch;
			out_valid_q    <= 1'b0;
		end else begin
			step_q <= step_next;

			if (cfg_we) begin
				case (cfg_index)
					CFG_CENTRE_X:  cx_q      <= cfg_data[CoordBits-1:0];
					CFG_CENTRE_Y:  cy_q      <= cfg_data[CoordBits-1:0];
					CFG_ARC_START: start_q   <= cfg_data[AngW-1:0];
					CFG_ARC_SWEEP: sweep_q   <= cfg_data[AngW-1:0];
					CFG_ENABLED:   enabled_q <= cfg_data[0];
					default: ;
				endcase
			end

			// Down starts a drag, up and cancel end it; disabled leaves it alone.
			if (beat_in && enabled_q) begin
				if (action == ActDown) begin
					dragging_q <= 1'b1;
				end else if (action == ActUp || action == ActCancel) begin
					dragging_q <= 1'b0;
				end
			end

			if (uw.op == OP_COMMIT) begin
				slider_level_q <= lvl_new;
			end

			// A new result may replace one that leaves at the same edge.
			if (uw.op == OP_EMIT && !out_busy) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers, driven by the op field of the control word.
	always_ff @(posedge clk) begin
		case (uw.op)
			OP_LATCH: begin
				if (beat_in) begin
					tx_q      <= touch_x;
					ty_q      <= touch_y;
					handled_q <= enabled_q;
					track_q   <= enabled_q &&
						((action == ActDown) || (action == ActMove && dragging_q));
					ang_q     <= '0;
					changed_q <= 1'b0;
				end
			end
			OP_DELTA: begin
				dx_q <= {1'b0, tx_q} - {1'b0, cx_q};
				dy_q <= {1'b0, ty_q} - {1'b0, cy_q};
			end
			OP_ATAN_SETUP: begin
				xneg_q  <= dx_q[DeltaW-1];
				yneg_q  <= dy_q[DeltaW-1];
				steep_q <= steep;
				zero_q  <= (mx == '0);
				rem_q   <= RemW'(mn) * RemW'(AtanScale);
				dsh_q   <= RemW'(mx) << (AtanQBits - 1);
				quo_q   <= '0;
				cnt_q   <= CntW'(AtanQBits - 1);
			end
			OP_DIV: begin
				if (div_ge) begin
					rem_q <= rem_q - dsh_q;
				end
				dsh_q <= dsh_q >> 1;
				quo_q <= {quo_q[QuoW-2:0], div_ge};
				cnt_q <= cnt_q - CntW'(1);
			end
			OP_ANGLE: begin
				ang_q <= ang_new;
			end
			OP_REL: begin
				rel_q <= rel_new;
				sw_q  <= sw_new;
			end
			OP_SCALE_SETUP: begin
				inside_q <= in_arc;
				snap_q   <= snap_new;
				rem_q    <= RemW'(rel_q) * RemW'(PctScale);
				dsh_q    <= RemW'(sw_q) << (ScaleQBits - 1);
				quo_q    <= '0;
				cnt_q    <= CntW'(ScaleQBits - 1);
			end
			OP_COMMIT: begin
				changed_q <= (lvl_new != slider_level_q);
			end
			OP_EMIT: begin
				if (!out_busy) begin
					out_handled_q <= handled_q;
					out_level_q   <= slider_level_q;
					out_changed_q <= changed_q;
					out_angle_q   <= ang_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign handled       = out_handled_q;
	assign level         = out_level_q;
	assign level_changed = out_changed_q;
	assign angle_deg     = out_angle_q;

	// A shown level never leaves the 0 to 100 range.
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (level <= Pct100))
		else $error("level above 100");

	// A shown angle stays below a full turn.
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (angle_deg < Deg360))
		else $error("angle not below 360");

	// An ignored beat reports neither a change nor an angle.
	a_unhandled_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !handled) |-> (!level_changed && angle_deg == '0))
		else $error("unhandled beat reports a change or an angle");

	// Up or cancel while enabled ends the drag on the next cycle.
	a_drag_end: assert property (@(posedge clk) disable iff (!arst_n)
		(beat_in && enabled_q && (action == ActUp || action == ActCancel))
		|=> !dragging_q)
		else $error("drag not ended by up or cancel");

	// The level division always runs with a nonzero sweep as its divisor.
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(uw.op == OP_DIV && step_q == StepScaleDiv) |-> (sw_q != '0))
		else $error("level divided by a zero sweep");

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the arc slider touch position core.
module tb_top
	import tasp_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// Clock period and run controls. The stall limit covers the longest
	// correct quiet spell: the receiver hold-off of HoldCycles plus one tracked
	// beat and a few random idle cycles on either side.
	localparam int ClkPeriod   = 10;
	localparam int ResetCycles = 11;
	localparam int IdlePct     = 26;
	localparam int HoldCycles  = 300;
	localparam int StallLimit  = 2000;
	localparam int DrainCycles = 25;
	localparam int PhaseItems  = 140;
	localparam int RandPhases  = 12;
	localparam int CoordMax    = (1 << CoordBits) - 1;

	// One touch event as it is driven onto the input channel.
	typedef struct packed {
		logic [1:0]           action;
		logic [CoordBits-1:0] x;
		logic [CoordBits-1:0] y;
	} touch_t;

	// One slider report as it leaves the result channel.
	typedef struct packed {
		logic              handled;
		logic [LevelW-1:0] level;
		logic              level_changed;
		logic [AngW-1:0]   angle_deg;
	} slider_report_t;

	// Every block input starts at a known value before reset is released.
	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 in_valid      = 1'b0;
	logic                 in_ready;
	logic [1:0]           action        = ActDown;
	logic [CoordBits-1:0] touch_x       = '0;
	logic [CoordBits-1:0] touch_y       = '0;
	logic                 out_valid;
	logic                 out_ready     = 1'b0;
	logic                 handled;
	logic [LevelW-1:0]    level;
	logic                 level_changed;
	logic [AngW-1:0]      angle_deg;
	logic                 cfg_we        = 1'b0;
	logic [CfgIdxW-1:0]   cfg_index     = CFG_CENTRE_X;
	logic [CfgDataW-1:0]  cfg_data      = '0;

	// Shadow of the block's registers and state, kept by the predictor.
	logic [CoordBits-1:0] centre_x_q = '0;
	logic [CoordBits-1:0] centre_y_q = '0;
	logic [AngW-1:0]      start_q    = StartRst;
	logic [AngW-1:0]      sweep_q    = SweepRst;
	logic                 enabled_q  = 1'b1;
	logic                 dragging_q = 1'b0;
	logic [LevelW-1:0]    level_q    = '0;

	touch_t         pending_touches[$];
	slider_report_t expected_reports[$];
	touch_t         next_touch;
	slider_report_t got_report;
	slider_report_t want_report;

	int touches_queued  = 0;
	int touches_sent    = 0;
	int reports_checked = 0;
	int mismatches      = 0;
	int tracked_events  = 0;
	int level_changes   = 0;
	int ignored_events  = 0;
	int phases_run      = 0;
	int hold_left       = 0;
	int hold_count      = 0;
	int quiet_cycles    = 0;
	logic steady;

	touch_arc_slider_position_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.touch_x      (touch_x),
		.touch_y      (touch_y),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.handled      (handled),
		.level        (level),
		.level_changed(level_changed),
		.angle_deg    (angle_deg),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #(ClkPeriod / 2) clk = ~clk;

	// A window in the middle of the run where neither side idles, so the block
	// also sees back-to-back traffic at its full rate.
	assign steady = (reports_checked >= 700) && (reports_checked < 1000);

	// Octant-linear bearing of a point around the centre, in degrees clockwise
	// from the right with screen y pointing down. Points on an axis are exact.
	function automatic logic [AngW-1:0] touch_bearing(input int dx, input int dy);
		int ax;
		int ay;
		int deg;
		if (dx == 0 && dy == 0) return '0;
		if (dx == 0) return (dy > 0) ? AngW'(90) : AngW'(270);
		if (dy == 0) return (dx > 0) ? AngW'(0) : AngW'(180);
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
		if (ax >= ay) deg = (45 * ay) / ax;
		else deg = 90 - (45 * ax) / ay;
		if (dx < 0) deg = 180 - deg;
		if (dy < 0) deg = 360 - deg;
		return AngW'(deg % 360);
	endfunction

	// Works out the report for one accepted touch beat and advances the
	// shadow drag flag and slider level the way the block should.
	function automatic slider_report_t predict_report(input touch_t ev);
		slider_report_t r;
		int dx;
		int dy;
		int rel;
		int arc_start;
		int arc_span;
		int lvl;
		r.handled       = 1'b0;
		r.level_changed = 1'b0;
		r.angle_deg     = '0;
		r.level         = level_q;
		if (!enabled_q) begin
			// A disabled slider leaves its state alone and reports nothing new.
			ignored_events++;
			return r;
		end
		r.handled = 1'b1;
		if (ev.action == ActDown || (ev.action == ActMove && dragging_q)) begin
			if (ev.action == ActDown) dragging_q = 1'b1;
			dx = int'(ev.x) - int'(centre_x_q);
			dy = int'(ev.y) - int'(centre_y_q);
			r.angle_deg = touch_bearing(dx, dy);
			// Start wraps modulo a full turn; a zero sweep acts as one degree.
			arc_start = int'(start_q) % 360;
			arc_span  = (sweep_q == '0) ? 1 : int'(sweep_q);
			if (int'(r.angle_deg) >= arc_start) rel = int'(r.angle_deg) - arc_start;
			else rel = int'(r.angle_deg) + 360 - arc_start;
			// Outside the arc the level snaps to the nearer end, ties to full.
			if (rel <= arc_span) lvl = (rel * 100) / arc_span;
			else if (360 - rel < rel - arc_span) lvl = 0;
			else lvl = 100;
			if (lvl > 100) lvl = 100;
			if (LevelW'(lvl) != level_q) begin
				level_q = LevelW'(lvl);
				r.level_changed = 1'b1;
				level_changes++;
			end
			tracked_events++;
		end else if (ev.action == ActUp || ev.action == ActCancel) begin
			dragging_q = 1'b0;
		end
		r.level = level_q;
		return r;
	endfunction

	// Input driver. At each edge it first logs the beat that was just taken,
	// then either presents the next pending touch or idles. Valid
	// is only ever changed when the channel is free, so a payload is held
	// stable until the block takes it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_reports.push_back(predict_report(touch_t'{action, touch_x, touch_y}));
				touches_sent++;
			end
			if (!in_valid || in_ready) begin
				if (pending_touches.size() != 0 &&
				    (steady || $urandom_range(0, 99) >= IdlePct)) begin
					next_touch = pending_touches.pop_front();
					in_valid <= 1'b1;
					action   <= next_touch.action;
					touch_x  <= next_touch.x;
					touch_y  <= next_touch.y;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver. Every accepted report is checked against
	// the oldest expectation field by field. Ready drops at random, and twice
	// during the run it stays low for a long stretch while touches are still
	// queued, so the block's output backs up and it has to stall its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got_report = slider_report_t'{handled, level, level_changed, angle_deg};
				if (expected_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected report h=%0d lvl=%0d chg=%0d ang=%0d",
						         $realtime, handled, level, level_changed, angle_deg);
				end else begin
					want_report = expected_reports.pop_front();
					reports_checked++;
					if (got_report != want_report) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: report %0d exp h=%0d l=%0d c=%0d a=%0d %s",
							         $realtime, reports_checked,
							         want_report.handled, want_report.level,
							         want_report.level_changed, want_report.angle_deg,
							         $sformatf("got h=%0d l=%0d c=%0d a=%0d",
							                   got_report.handled, got_report.level,
							                   got_report.level_changed,
							                   got_report.angle_deg));
					end
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_count < 2 && reports_checked >= 400 * (hold_count + 1) &&
			             pending_touches.size() > 30) begin
				hold_left = HoldCycles;
				hold_count++;
				out_ready <= 1'b0;
			end else begin
				out_ready <= steady || $urandom_range(0, 99) >= IdlePct;
			end
		end
	end

	// Watchdog: ends the run if no beat moves on either channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= StallLimit) begin
				$display("%0t: no beat on either channel for %0d cycles", $realtime, StallLimit);
				$display("TEST FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// One register write; the enable stays high across back-to-back writes
	// and is dropped by the caller once the writes are done.
	task automatic write_reg(input cfg_idx_t idx, input int value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CfgDataW'(value);
		case (idx)
			CFG_CENTRE_X:  centre_x_q = CoordBits'(value);
			CFG_CENTRE_Y:  centre_y_q = CoordBits'(value);
			CFG_ARC_START: start_q    = AngW'(value);
			CFG_ARC_SWEEP: sweep_q    = AngW'(value);
			CFG_ENABLED:   enabled_q  = value[0];
			default: ;
		endcase
	endtask

	// Programs the whole arc geometry and the enable, then hands the bus back.
	task automatic set_arc(input int cx, input int cy, input int start,
	                       input int sweep, input int en);
		write_reg(CFG_CENTRE_X, cx);
		write_reg(CFG_CENTRE_Y, cy);
		write_reg(CFG_ARC_START, start);
		write_reg(CFG_ARC_SWEEP, sweep);
		write_reg(CFG_ENABLED, en);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		phases_run++;
	endtask

	task automatic add_touch(input logic [1:0] act, input int x, input int y);
		pending_touches.push_back(touch_t'{act, CoordBits'(x), CoordBits'(y)});
		touches_queued++;
	endtask

	// Sender pause: nothing new goes out until every report has come back, and
	// then the block gets a few more cycles before its registers change.
	task automatic wait_idle();
		while (reports_checked != touches_queued) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	// Picks one coordinate: mostly anywhere on the screen, sometimes on a screen edge, on
	// or right next to the centre line, which gives axis points and the centre itself.
	function automatic int pick_coord(input int centre);
		int v;
		case ($urandom_range(0, 9))
			6, 7: begin
				v = centre + int'($urandom_range(0, 8)) - 4;
				if (v < 0) v = 0;
				if (v > CoordMax) v = CoordMax;
			end
			8: v = centre;
			9: v = $urandom_range(0, 1) ? CoordMax : 0;
			default: v = $urandom_range(0, CoordMax);
		endcase
		return v;
	endfunction

	// Mostly complete drags (down, a run of moves, then up or cancel) with
	// random points; the rest are stray single events of any kind.
	task automatic queue_drags(input int count);
		int left;
		int moves;
		left = count;
		while (left > 0) begin
			if ($urandom_range(0, 9) < 8) begin
				add_touch(ActDown, pick_coord(int'(centre_x_q)), pick_coord(int'(centre_y_q)));
				moves = $urandom_range(1, 8);
				for (int k = 0; k < moves; k++)
					add_touch(ActMove, pick_coord(int'(centre_x_q)), pick_coord(int'(centre_y_q)));
				add_touch(($urandom_range(0, 3) == 0) ? ActCancel : ActUp,
				          $urandom_range(0, CoordMax), $urandom_range(0, CoordMax));
				left -= moves + 2;
			end else begin
				add_touch(2'($urandom_range(0, 3)),
				          $urandom_range(0, CoordMax), $urandom_range(0, CoordMax));
				left--;
			end
		end
	endtask

	initial begin
		repeat (ResetCycles) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset geometry: a move with no drag, a down right on the centre, a
		// drag past the far end, then up, a move with no drag and cancel.
		add_touch(ActMove, CoordMax, CoordMax);
		add_touch(ActDown, 0, 0);
		add_touch(ActMove, CoordMax, CoordMax);
		add_touch(ActUp, CoordMax, 0);
		add_touch(ActMove, 100, 100);
		add_touch(ActCancel, 0, CoordMax);
		wait_idle();

		// Full circle from zero: every axis and both screen corners.
		set_arc(2048, 2048, 0, 360, 1);
		add_touch(ActDown, CoordMax, 2048);
		add_touch(ActMove, 2048, CoordMax);
		add_touch(ActMove, 0, 2048);
		add_touch(ActMove, 2048, 0);
		add_touch(ActMove, 0, 0);
		add_touch(ActMove, CoordMax, CoordMax);
		add_touch(ActCancel, 2048, 2048);
		wait_idle();

		// Half arc: a point straight up sits equally far from both ends and
		// must snap to full; the others snap to the nearer end.
		set_arc(2048, 2048, 0, 180, 1);
		add_touch(ActDown, 2048, 0);
		add_touch(ActMove, 3000, 1000);
		add_touch(ActMove, 1000, 1900);
		add_touch(ActUp, 0, 0);
		wait_idle();

		// Start beyond a full turn and a zero sweep.
		set_arc(CoordMax, 0, 400, 0, 1);
		add_touch(ActDown, 0, CoordMax);
		add_touch(ActMove, CoordMax, CoordMax);
		add_touch(ActCancel, 0, 0);
		wait_idle();

		// Sweep wider than a full turn never snaps.
		set_arc(0, CoordMax, 90, 500, 1);
		add_touch(ActDown, CoordMax, 0);
		add_touch(ActMove, 0, 0);
		add_touch(ActUp, CoordMax, CoordMax);
		wait_idle();

		// Disabled: every kind of event is passed over.
		set_arc(2048, 2048, 150, 240, 0);
		add_touch(ActDown, 3000, 3000);
		add_touch(ActMove, 1000, 3000);
		add_touch(ActUp, 0, 0);
		add_touch(ActCancel, CoordMax, CoordMax);
		wait_idle();

		// Random part: the first settings are the register extremes, the rest
		// random, now and then with the slider disabled for a short burst.
		for (int p = 0; p < RandPhases; p++) begin
			case (p)
				0: set_arc(0, 0, 0, 1, 1);
				1: set_arc(CoordMax, CoordMax, 359, 360, 1);
				2: set_arc(CoordMax, 0, 511, 511, 1);
				default: set_arc($urandom_range(0, CoordMax), $urandom_range(0, CoordMax),
				                 $urandom_range(0, 511), $urandom_range(0, 511), 1);
			endcase
			queue_drags(PhaseItems);
			wait_idle();
			if ($urandom_range(0, 3) == 0) begin
				write_reg(CFG_ENABLED, 0);
				@(posedge clk);
				cfg_we <= 1'b0;
				@(negedge clk);
				queue_drags(20);
				wait_idle();
			end
		end

		wait_idle();
		$display("Covered %0d touch beats over %0d register settings: %0d tracked,",
		         touches_sent, phases_run, tracked_events);
		$display("%0d level changes, %0d while disabled, %0d receiver hold-offs.",
		         level_changes, ignored_events, hold_count);
		if (mismatches == 0 && expected_reports.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
